// ===== sv/pld_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Piecewise linear arc delay: shared types and constants
// Field widths, fixed-point formats, register indexes and the structs that
// pass between the piece cells, the divider stages and the output buffer.
// ----------------------------------------------------------------------------
package pld_pkg;

  localparam int unsigned MAX_PIECES_DEF = 3;
  localparam int unsigned PIECE_REGS     = 3;

  // Input and configuration field widths.
  localparam int unsigned ARC_W  = 16;
  localparam int unsigned CAP_W  = 16;
  localparam int unsigned TT_W   = 32;
  localparam int unsigned VEH_W  = 17;
  localparam int unsigned THR_W  = 16;
  localparam int unsigned SLP_W  = 16;
  localparam int unsigned CNT_W  = 2;
  localparam int unsigned FRAC_W = 8;

  // Derived datapath widths.
  localparam int unsigned PROD_W = TT_W + SLP_W;     // travel_time * slope, Q.16
  localparam int unsigned TH_W   = THR_W + CAP_W;    // threshold in vehicles, Q.8
  localparam int unsigned VQ_W   = VEH_W + FRAC_W;   // vehicle count, Q.8
  localparam int unsigned HALF_W = TH_W / 2;
  localparam int unsigned MUL_W  = PROD_W + HALF_W;
  localparam int unsigned TERM_W = 56;               // clamp width of one term
  localparam int unsigned ACC_W  = 64;               // signed height and best
  localparam int unsigned DELAY_W = 48;

  // Divider: quotient bits resolved per pipeline stage.
  localparam int unsigned DIV_BITS   = 4;
  localparam int unsigned DIV_STAGES = PROD_W / DIV_BITS;

  // Stream and configuration port widths.
  localparam int unsigned S_TDATA_W  = 88;
  localparam int unsigned M_TDATA_W  = DELAY_W;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_PIECE_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_0     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_1     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SLOPE_2     = 3'd6;

  // Register reset values.
  localparam logic [CNT_W-1:0] PIECE_COUNT_RST = 2'd1;
  localparam logic [THR_W-1:0] THRESHOLD_0_RST = 16'd0;
  localparam logic [THR_W-1:0] THRESHOLD_1_RST = 16'd256;
  localparam logic [THR_W-1:0] THRESHOLD_2_RST = 16'd512;
  localparam logic [SLP_W-1:0] SLOPE_RST       = 16'd0;

  // One query as it travels down the chain of piece cells.
  typedef struct packed {
    logic                    zero;    // dummy arc, delay forced to zero
    logic [CAP_W-1:0]        cap;     // capacity, never zero
    logic [TT_W-1:0]         tt;
    logic [VEH_W-1:0]        veh;
    logic signed [ACC_W-1:0] height;
    logic signed [ACC_W-1:0] best;
  } item_t;

  // Query plus the thresholds of one piece, carried beside the divider.
  typedef struct packed {
    item_t           it;
    logic [TH_W-1:0] th;
    logic [TH_W-1:0] nth;
  } side_t;

  // Per-cell view of the configuration.
  typedef struct packed {
    logic             active;
    logic             has_next;
    logic [THR_W-1:0] thr;
    logic [THR_W-1:0] thr_next;
    logic [SLP_W-1:0] slp;
  } cell_cfg_t;

  typedef struct packed {
    logic [DELAY_W-1:0] delay;
    logic               sat;
  } res_t;

endpackage
`default_nettype wire

// ===== sv/piecewise_linear_arc_delay.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Piecewise linear arc delay
// Congestion delay of one arc from its capacity, free-flow travel time and
// vehicle count, under a piecewise linear function of up to three pieces.
// ----------------------------------------------------------------------------
// Queries enter on the s_axis channel and one result per query leaves on the
// m_axis channel, in order. The cfg channel writes the piece count, the
// piece thresholds and the piece slopes; it is always ready and should only
// be written while no query is in flight.
// Each piece is one cell of a chain; a cell holds a 12-stage divider
// (four quotient bits per stage) plus five stages of threshold, multiply and
// accumulate logic. A new query is taken every cycle while s_axis_tready_o
// is high.
// Reset empties the pipeline and the output buffer and loads the register
// defaults: one piece, thresholds 0, 1.0 and 2.0, all slopes zero.
// When the receiver stalls, the output register and a one-entry skid buffer
// absorb results; once the skid buffer is full, s_axis_tready_o drops and
// the whole chain holds until the output transfer completes.
// ----------------------------------------------------------------------------
module piecewise_linear_arc_delay #(
  parameter int unsigned MAX_PIECES = pld_pkg::MAX_PIECES_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  // arc_index [15:0], arc_capacity [31:16], travel_time [63:32],
  // vehicle_count [80:64], zeros above
  input  wire logic [pld_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  input  wire logic                             s_axis_tvalid_i,
  output logic                                  s_axis_tready_o,
  // delay [47:0]
  output logic [pld_pkg::M_TDATA_W-1:0]         m_axis_tdata_o,
  // saturated [0]
  output logic                                  m_axis_tuser_o,
  output logic                                  m_axis_tvalid_o,
  input  wire logic                             m_axis_tready_i,
  input  wire logic                             cfg_valid_i,
  output logic                                  cfg_ready_o,
  input  wire logic [pld_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  wire logic [pld_pkg::CFG_DATA_W-1:0]   cfg_data_i
);
  import pld_pkg::*;

  localparam int unsigned NUM_CELLS = (MAX_PIECES < PIECE_REGS) ? MAX_PIECES : PIECE_REGS;

  logic [CNT_W-1:0] pc_q;
  logic [THR_W-1:0] thr_q [PIECE_REGS];
  logic [SLP_W-1:0] slp_q [PIECE_REGS];

  logic             en;
  logic             cv  [NUM_CELLS+1];
  item_t            cit [NUM_CELLS+1];
  item_t            in_item;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q     <= PIECE_COUNT_RST;
      thr_q[0] <= THRESHOLD_0_RST;
      thr_q[1] <= THRESHOLD_1_RST;
      thr_q[2] <= THRESHOLD_2_RST;
      slp_q[0] <= SLOPE_RST;
      slp_q[1] <= SLOPE_RST;
      slp_q[2] <= SLOPE_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_PIECE_COUNT: pc_q     <= cfg_data_i[CNT_W-1:0];
        REG_THRESHOLD_0: thr_q[0] <= cfg_data_i;
        REG_THRESHOLD_1: thr_q[1] <= cfg_data_i;
        REG_THRESHOLD_2: thr_q[2] <= cfg_data_i;
        REG_SLOPE_0:     slp_q[0] <= cfg_data_i;
        REG_SLOPE_1:     slp_q[1] <= cfg_data_i;
        REG_SLOPE_2:     slp_q[2] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Unpack the query; a zero capacity counts as one vehicle.
  always_comb begin
    in_item.zero   = (s_axis_tdata_i[ARC_W-1:0] == '0);
    in_item.cap    = (s_axis_tdata_i[ARC_W+CAP_W-1:ARC_W] == '0) ? CAP_W'(1)
                     : s_axis_tdata_i[ARC_W+CAP_W-1:ARC_W];
    in_item.tt     = s_axis_tdata_i[ARC_W+CAP_W+TT_W-1:ARC_W+CAP_W];
    in_item.veh    = s_axis_tdata_i[ARC_W+CAP_W+TT_W+VEH_W-1:ARC_W+CAP_W+TT_W];
    in_item.height = '0;
    in_item.best   = '0;
  end

  assign cit[0]          = in_item;
  assign cv[0]           = s_axis_tvalid_i;
  assign s_axis_tready_o = en;

  for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
    cell_cfg_t        cfg_g;
    logic             has_next_g;
    logic [THR_W-1:0] thr_next_g;

    if (g + 1 < NUM_CELLS) begin : g_next
      assign has_next_g = 32'(g + 1) < {{(32-CNT_W){1'b0}}, pc_q};
      assign thr_next_g = thr_q[g+1];
    end else begin : g_end
      assign has_next_g = 1'b0;
      assign thr_next_g = '0;
    end

    assign cfg_g = '{active:   32'(g) < {{(32-CNT_W){1'b0}}, pc_q},
                     has_next: has_next_g,
                     thr:      thr_q[g],
                     thr_next: thr_next_g,
                     slp:      slp_q[g]};

    pld_cell u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .en_i        (en),
      .cfg_i       (cfg_g),
      .in_valid_i  (cv[g]),
      .in_item_i   (cit[g]),
      .out_valid_o (cv[g+1]),
      .out_item_o  (cit[g+1])
    );
  end

  pld_out u_out (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (cv[NUM_CELLS]),
    .in_item_i       (cit[NUM_CELLS]),
    .en_o            (en),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o)
  );

endmodule
`default_nettype wire

// ===== sv/pld_div_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Divider stage
// Resolves DIV_BITS quotient bits of a restoring division. The numerator is
// shifted out of the top of nq while quotient bits are shifted in below.
// ----------------------------------------------------------------------------
module pld_div_stage (
  input  wire logic                      clk_i,
  input  wire logic                      en_i,
  input  wire logic [pld_pkg::PROD_W-1:0] nq_i,
  input  wire logic [pld_pkg::CAP_W-1:0]  rem_i,
  input  wire logic [pld_pkg::CAP_W-1:0]  cap_i,
  output logic      [pld_pkg::PROD_W-1:0] nq_o,
  output logic      [pld_pkg::CAP_W-1:0]  rem_o
);
  import pld_pkg::*;

  logic [PROD_W-1:0] nq_d;
  logic [CAP_W-1:0]  rem_d;

  always_comb begin
    logic [CAP_W:0]    r;
    logic [PROD_W-1:0] q;
    r = {1'b0, rem_i};
    q = nq_i;
    for (int k = 0; k < DIV_BITS; k++) begin
      r = {r[CAP_W-1:0], q[PROD_W-1]};
      q = {q[PROD_W-2:0], 1'b0};
      if (r >= {1'b0, cap_i}) begin
        r    = r - {1'b0, cap_i};
        q[0] = 1'b1;
      end
    end
    nq_d  = q;
    rem_d = r[CAP_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      nq_o  <= nq_d;
      rem_o <= rem_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pld_cell.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Piece cell
// Handles one piece of the delay function: threshold and slope of the piece,
// the candidate delay above its threshold and the height it adds for the
// following piece. Fully pipelined, hands the query to the next cell.
// ----------------------------------------------------------------------------
module pld_cell (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                en_i,
  input  wire pld_pkg::cell_cfg_t  cfg_i,
  input  wire logic                in_valid_i,
  input  wire pld_pkg::item_t      in_item_i,
  output logic                     out_valid_o,
  output pld_pkg::item_t           out_item_o
);
  import pld_pkg::*;

  // Entry stage and divider shift line.
  logic              sv_q   [DIV_STAGES+1];
  side_t             side_q [DIV_STAGES+1];
  logic [PROD_W-1:0] nq_w   [DIV_STAGES+1];
  logic [CAP_W-1:0]  rem_w  [DIV_STAGES+1];
  logic [PROD_W-1:0] nq0_q;
  logic [TH_W-1:0]   th0, nth0;
  logic [PROD_W-1:0] prod0;

  // Difference, multiply, term and accumulate stages.
  logic              v1_q, v2_q, v3_q;
  item_t             it1_q, it2_q, it3_q;
  logic [PROD_W-1:0] slope1_q;
  logic [TH_W-1:0]   dc1_q, dh1_q;
  logic              gt1_q, gt2_q, gt3_q;
  logic              hneg1_q, hneg2_q, hneg3_q;
  logic [MUL_W-1:0]  pch2_q, pcl2_q, phh2_q, phl2_q;
  logic [TERM_W-1:0] tc3_q, thh3_q;

  logic [TH_W-1:0]   vq;
  logic              gt_d, hneg_d;
  logic [TH_W-1:0]   dc_d, dh_d;
  logic [MUL_W:0]    sumc, sumh;
  logic [TERM_W-1:0] tc_d, thh_d;
  logic signed [ACC_W-1:0] cand, best_d, height_d;
  item_t             out_d;

  assign th0   = {{CAP_W{1'b0}}, cfg_i.thr} * {{THR_W{1'b0}}, in_item_i.cap};
  assign nth0  = {{CAP_W{1'b0}}, cfg_i.thr_next} * {{THR_W{1'b0}}, in_item_i.cap};
  assign prod0 = {{SLP_W{1'b0}}, in_item_i.tt} * {{TT_W{1'b0}}, cfg_i.slp};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= DIV_STAGES; k++) sv_q[k] <= 1'b0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (en_i) begin
      sv_q[0] <= in_valid_i;
      for (int k = 0; k < DIV_STAGES; k++) sv_q[k+1] <= sv_q[k];
      v1_q        <= sv_q[DIV_STAGES];
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      out_valid_o <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      side_q[0].it  <= in_item_i;
      side_q[0].th  <= th0;
      side_q[0].nth <= nth0;
      nq0_q         <= prod0;
      for (int k = 0; k < DIV_STAGES; k++) side_q[k+1] <= side_q[k];
    end
  end

  assign nq_w[0]  = nq0_q;
  assign rem_w[0] = '0;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    pld_div_stage u_div (
      .clk_i (clk_i),
      .en_i  (en_i),
      .nq_i  (nq_w[g]),
      .rem_i (rem_w[g]),
      .cap_i (side_q[g].it.cap),
      .nq_o  (nq_w[g+1]),
      .rem_o (rem_w[g+1])
    );
  end

  // Distance of the vehicle count above the threshold, and the signed
  // width of this piece up to the next threshold.
  always_comb begin
    vq     = {{(TH_W-VQ_W){1'b0}}, side_q[DIV_STAGES].it.veh, {FRAC_W{1'b0}}};
    gt_d   = vq > side_q[DIV_STAGES].th;
    dc_d   = vq - side_q[DIV_STAGES].th;
    hneg_d = side_q[DIV_STAGES].nth < side_q[DIV_STAGES].th;
    dh_d   = hneg_d ? side_q[DIV_STAGES].th - side_q[DIV_STAGES].nth
                    : side_q[DIV_STAGES].nth - side_q[DIV_STAGES].th;
  end

  // Slope times distance, split into high and low halves of the distance;
  // the result is floored to Q.8 and clamped.
  always_comb begin
    sumc  = {1'b0, pch2_q} + {{(HALF_W+1){1'b0}}, pcl2_q[MUL_W-1:HALF_W]};
    sumh  = {1'b0, phh2_q} + {{(HALF_W+1){1'b0}}, phl2_q[MUL_W-1:HALF_W]};
    tc_d  = (|sumc[MUL_W:TERM_W]) ? {TERM_W{1'b1}} : sumc[TERM_W-1:0];
    thh_d = (|sumh[MUL_W:TERM_W]) ? {TERM_W{1'b1}} : sumh[TERM_W-1:0];
  end

  always_comb begin
    cand   = it3_q.height + $signed({{(ACC_W-TERM_W){1'b0}}, tc3_q});
    best_d = (cfg_i.active && gt3_q && (cand > it3_q.best)) ? cand : it3_q.best;
    if (!cfg_i.has_next) begin
      height_d = it3_q.height;
    end else if (hneg3_q) begin
      height_d = it3_q.height - $signed({{(ACC_W-TERM_W){1'b0}}, thh3_q});
    end else begin
      height_d = it3_q.height + $signed({{(ACC_W-TERM_W){1'b0}}, thh3_q});
    end
    out_d        = it3_q;
    out_d.best   = best_d;
    out_d.height = height_d;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      it1_q    <= side_q[DIV_STAGES].it;
      slope1_q <= nq_w[DIV_STAGES];
      dc1_q    <= dc_d;
      dh1_q    <= dh_d;
      gt1_q    <= gt_d;
      hneg1_q  <= hneg_d;

      it2_q   <= it1_q;
      gt2_q   <= gt1_q;
      hneg2_q <= hneg1_q;
      pch2_q  <= {{HALF_W{1'b0}}, slope1_q} * {{PROD_W{1'b0}}, dc1_q[TH_W-1:HALF_W]};
      pcl2_q  <= {{HALF_W{1'b0}}, slope1_q} * {{PROD_W{1'b0}}, dc1_q[HALF_W-1:0]};
      phh2_q  <= {{HALF_W{1'b0}}, slope1_q} * {{PROD_W{1'b0}}, dh1_q[TH_W-1:HALF_W]};
      phl2_q  <= {{HALF_W{1'b0}}, slope1_q} * {{PROD_W{1'b0}}, dh1_q[HALF_W-1:0]};

      it3_q   <= it2_q;
      gt3_q   <= gt2_q;
      hneg3_q <= hneg2_q;
      tc3_q   <= tc_d;
      thh3_q  <= thh_d;

      out_item_o <= out_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/pld_out.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Result buffer
// Saturates the final delay and holds it in an output register with a
// one-entry skid stage, so that upstream ready comes from a register only.
// ----------------------------------------------------------------------------
module pld_out (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  input  wire pld_pkg::item_t                 in_item_i,
  output logic                                en_o,
  output logic                                m_axis_tvalid_o,
  input  wire logic                           m_axis_tready_i,
  output logic [pld_pkg::M_TDATA_W-1:0]       m_axis_tdata_o,  // delay
  output logic                                m_axis_tuser_o   // saturated
);
  import pld_pkg::*;

  res_t res_in;
  res_t out_q, out_d, skid_q, skid_d;
  logic out_v_q, out_v_d, skid_v_q, skid_v_d;
  logic arr, ovf;

  // The best candidate is never negative, so upper bits flag overflow.
  always_comb begin
    ovf = |in_item_i.best[ACC_W-1:DELAY_W];
    if (in_item_i.zero) begin
      res_in.delay = '0;
      res_in.sat   = 1'b0;
    end else begin
      res_in.delay = ovf ? {DELAY_W{1'b1}} : in_item_i.best[DELAY_W-1:0];
      res_in.sat   = ovf;
    end
  end

  assign en_o = !skid_v_q;
  assign arr  = in_valid_i && en_o;

  always_comb begin
    out_v_d  = out_v_q;
    out_d    = out_q;
    skid_v_d = skid_v_q;
    skid_d   = skid_q;
    if (!out_v_q || m_axis_tready_i) begin
      if (skid_v_q) begin
        out_v_d  = 1'b1;
        out_d    = skid_q;
        skid_v_d = arr;
        skid_d   = res_in;
      end else begin
        out_v_d  = arr;
        out_d    = res_in;
        skid_v_d = 1'b0;
      end
    end else if (arr) begin
      skid_v_d = 1'b1;
      skid_d   = res_in;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      out_v_q  <= out_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    skid_q <= skid_d;
  end

  assign m_axis_tvalid_o = out_v_q;
  assign m_axis_tdata_o  = out_q.delay;
  assign m_axis_tuser_o  = out_q.sat;

endmodule
`default_nettype wire

// ===== sim/pld_arc_delay_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear arc delay: result checker
// Watches the query, result and register channels of the block, keeps its
// own copy of the piece registers, computes the congestion delay of every
// accepted query and compares each result transfer with the oldest one.
// ----------------------------------------------------------------------------
module pld_arc_delay_checker (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic [pld_pkg::S_TDATA_W-1:0]      s_axis_tdata_i,
  input  logic                               s_axis_tvalid_i,
  input  logic                               s_axis_tready_i,
  input  logic [pld_pkg::M_TDATA_W-1:0]      m_axis_tdata_i,
  input  logic                               m_axis_tuser_i,
  input  logic                               m_axis_tvalid_i,
  input  logic                               m_axis_tready_i,
  input  logic                               cfg_valid_i,
  input  logic                               cfg_ready_i,
  input  logic [pld_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pld_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  output int                                 fail_count_o,
  output int                                 pending_o,
  output int                                 checked_o,
  output int                                 saturated_o
);
  import pld_pkg::*;

  localparam logic [63:0] TERM_CAP  = (64'd1 << TERM_W) - 64'd1;
  localparam logic [63:0] DELAY_CAP = (64'd1 << DELAY_W) - 64'd1;

  logic [CNT_W-1:0] piece_cnt;
  logic [THR_W-1:0] thr_frac [PIECE_REGS];
  logic [SLP_W-1:0] slp_rel  [PIECE_REGS];

  res_t expected_delays [$];
  int   fails   = 0;
  int   checked = 0;
  int   sats    = 0;

  // floor(slope * d / 2^16) with the magnitude clamped to the term limit.
  function automatic logic [63:0] scaled_q8(input logic [63:0] slope, input logic [63:0] d);
    logic [63:0] acc;
    logic [63:0] d_hi;
    logic [63:0] d_lo;
    d_hi = d[31:16];
    d_lo = d[15:0];
    acc  = slope * d_hi;
    if (acc > TERM_CAP) return TERM_CAP;
    acc = acc + ((slope * d_lo) >> 16);
    return (acc > TERM_CAP) ? TERM_CAP : acc;
  endfunction

  function automatic res_t congestion_delay(input logic [ARC_W-1:0] arc,
                                            input logic [CAP_W-1:0] cap_in,
                                            input logic [TT_W-1:0]  tt,
                                            input logic [VEH_W-1:0] veh);
    logic [63:0] cap;
    logic [63:0] tt_w;
    logic [63:0] vq;
    logic [63:0] th;
    logic [63:0] nth;
    logic [63:0] slope;
    logic [63:0] best_u;
    longint      height;
    longint      best;
    longint      cand;
    int          n;
    int          i;
    res_t        r;
    r = '0;
    if (arc == '0) return r;
    cap    = (cap_in == '0) ? 64'd1 : cap_in;
    tt_w   = tt;
    vq     = {veh, 8'd0};
    n      = piece_cnt;
    if (n > MAX_PIECES_DEF) n = MAX_PIECES_DEF;
    if (n > PIECE_REGS) n = PIECE_REGS;
    height = 0;
    best   = 0;
    for (i = 0; i < n; i++) begin
      th    = thr_frac[i] * cap;
      slope = (tt_w * slp_rel[i]) / cap;
      if (vq > th) begin
        cand = height + $signed(scaled_q8(slope, vq - th));
        if (cand > best) best = cand;
      end
      if (i + 1 < n) begin
        nth = thr_frac[i+1] * cap;
        // A falling threshold pulls the height of the later pieces down.
        if (nth >= th) height = height + $signed(scaled_q8(slope, nth - th));
        else           height = height - $signed(scaled_q8(slope, th - nth));
      end
    end
    if (best > $signed(DELAY_CAP)) begin
      r.delay = DELAY_CAP[DELAY_W-1:0];
      r.sat   = 1'b1;
    end else begin
      best_u  = best;
      r.delay = best_u[DELAY_W-1:0];
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      piece_cnt   <= PIECE_COUNT_RST;
      thr_frac[0] <= THRESHOLD_0_RST;
      thr_frac[1] <= THRESHOLD_1_RST;
      thr_frac[2] <= THRESHOLD_2_RST;
      slp_rel[0]  <= SLOPE_RST;
      slp_rel[1]  <= SLOPE_RST;
      slp_rel[2]  <= SLOPE_RST;
    end else if (cfg_valid_i && cfg_ready_i) begin
      case (cfg_index_i)
        REG_PIECE_COUNT: piece_cnt   <= cfg_data_i[CNT_W-1:0];
        REG_THRESHOLD_0: thr_frac[0] <= cfg_data_i;
        REG_THRESHOLD_1: thr_frac[1] <= cfg_data_i;
        REG_THRESHOLD_2: thr_frac[2] <= cfg_data_i;
        REG_SLOPE_0:     slp_rel[0]  <= cfg_data_i;
        REG_SLOPE_1:     slp_rel[1]  <= cfg_data_i;
        REG_SLOPE_2:     slp_rel[2]  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin : compare
    res_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_i && m_axis_tready_i) begin
        if (expected_delays.size() == 0) begin
          $error("result transfer with no query outstanding: delay %0h, saturated %0b",
                 m_axis_tdata_i, m_axis_tuser_i);
          fails++;
        end else begin
          want = expected_delays.pop_front();
          if (want.delay !== m_axis_tdata_i) begin
            $error("delay: expected %0h, actual %0h", want.delay, m_axis_tdata_i);
            fails++;
          end
          if (want.sat !== m_axis_tuser_i) begin
            $error("saturated: expected %0b, actual %0b", want.sat, m_axis_tuser_i);
            fails++;
          end
          checked++;
          if (want.sat) sats++;
        end
      end
      if (s_axis_tvalid_i && s_axis_tready_i) begin
        expected_delays.insert(expected_delays.size(),
                               congestion_delay(s_axis_tdata_i[15:0],
                                                s_axis_tdata_i[31:16],
                                                s_axis_tdata_i[63:32],
                                                s_axis_tdata_i[80:64]));
      end
    end
    fail_count_o <= fails;
    pending_o    <= expected_delays.size();
    checked_o    <= checked;
    saturated_o  <= sats;
  end

endmodule

// ===== sim/piecewise_linear_arc_delay_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Piecewise linear arc delay: regression testbench
// Drives delay queries and register settings into the block with random
// gaps on the query side and random stalls on the result side; a separate
// checker predicts every delay and reports mismatches.
// ----------------------------------------------------------------------------
module piecewise_linear_arc_delay_tb;
  import pld_pkg::*;

  localparam int GAP_MAX        = 12;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int DRAIN_CYCLES   = 64;
  localparam int RANDOM_PHASES  = 10;
  localparam int PHASE_QUERIES  = 110;
  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  logic                   clk_i;
  logic                   rst_ni;
  logic [S_TDATA_W-1:0]   s_axis_tdata_i;
  logic                   s_axis_tvalid_i;
  logic                   s_axis_tready_o;
  logic [M_TDATA_W-1:0]   m_axis_tdata_o;
  logic                   m_axis_tuser_o;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i;
  logic                   cfg_valid_i;
  logic                   cfg_ready_o;
  logic [CFG_IDX_W-1:0]   cfg_index_i;
  logic [CFG_DATA_W-1:0]  cfg_data_i;

  int fail_count;
  int pending;
  int checked;
  int saturated;

  // Settings as last written, used only to aim vehicle counts at thresholds.
  logic [CNT_W-1:0] aim_pc;
  logic [THR_W-1:0] aim_thr [PIECE_REGS];

  int queries_sent    = 0;
  int settings_loaded = 0;
  int idle_cycles     = 0;
  bit send_burst      = 1'b0;
  bit take_burst      = 1'b0;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  piecewise_linear_arc_delay u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  pld_arc_delay_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_i (s_axis_tready_o),
    .m_axis_tdata_i  (m_axis_tdata_o),
    .m_axis_tuser_i  (m_axis_tuser_o),
    .m_axis_tvalid_i (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .checked_o       (checked),
    .saturated_o     (saturated)
  );

  // Valid stays high across back-to-back queries; it only drops for a gap.
  task automatic send_query(input logic [ARC_W-1:0] arc, input logic [CAP_W-1:0] cap,
                            input logic [TT_W-1:0] tt, input logic [VEH_W-1:0] veh);
    int gap;
    gap = send_burst ? 0 : $urandom_range(0, GAP_MAX);
    if ($urandom_range(0, 31) == 0) send_burst = !send_burst;
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tdata_i  <= {7'd0, veh, tt, cap, arc};
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    queries_sent++;
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic load_setting(input logic [CNT_W-1:0] pc,
                              input logic [THR_W-1:0] t0, input logic [THR_W-1:0] t1,
                              input logic [THR_W-1:0] t2, input logic [SLP_W-1:0] s0,
                              input logic [SLP_W-1:0] s1, input logic [SLP_W-1:0] s2);
    logic [CFG_DATA_W-1:0] pc_word;
    // Upper bits of the piece count word are don't-care and get random data.
    pc_word = $urandom;
    pc_word[CNT_W-1:0] = pc;
    write_reg(REG_PIECE_COUNT, pc_word);
    write_reg(REG_THRESHOLD_0, t0);
    write_reg(REG_THRESHOLD_1, t1);
    write_reg(REG_THRESHOLD_2, t2);
    write_reg(REG_SLOPE_0, s0);
    write_reg(REG_SLOPE_1, s1);
    write_reg(REG_SLOPE_2, s2);
    write_reg(REG_UNMAPPED, $urandom);
    cfg_valid_i <= 1'b0;
    aim_pc     = pc;
    aim_thr[0] = t0;
    aim_thr[1] = t1;
    aim_thr[2] = t2;
    settings_loaded++;
  endtask

  // The checker's pending count is registered, so look only after the next edge.
  task automatic wait_drained();
    s_axis_tvalid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
  endtask

  task automatic random_query();
    logic [ARC_W-1:0] arc;
    logic [CAP_W-1:0] cap;
    logic [TT_W-1:0]  tt;
    logic [VEH_W-1:0] veh;
    logic [63:0]      cap_eff;
    logic [63:0]      boundary;
    int               k;
    arc = ($urandom_range(0, 15) == 0) ? '0 : $urandom;
    case ($urandom_range(0, 7))
      0, 1, 2: cap = $urandom_range(1, 16);
      3, 4:    cap = $urandom_range(1, 1024);
      5, 6:    cap = $urandom;
      default: cap = $urandom_range(0, 1) ? 16'h0000 : 16'hFFFF;
    endcase
    case ($urandom_range(0, 3))
      0:       tt = $urandom;
      1:       tt = $urandom_range(0, 4095);
      default: tt = $urandom_range(0, 24'hFFFFFF);
    endcase
    if ($urandom_range(0, 2) != 0 && aim_pc != 0) begin
      // Land just below, on, or just above a piece threshold.
      k        = $urandom_range(0, aim_pc - 1);
      cap_eff  = (cap == '0) ? 64'd1 : cap;
      boundary = ((aim_thr[k] * cap_eff) >> 8) + $urandom_range(0, 2);
      if (boundary != 0) boundary = boundary - 1;
      veh = (boundary > 64'h1FFFF) ? 17'h1FFFF : boundary[VEH_W-1:0];
    end else if ($urandom_range(0, 1) == 0) begin
      veh = $urandom;
    end else begin
      veh = $urandom_range(0, 64);
    end
    send_query(arc, cap, tt, veh);
  endtask

  initial begin : result_sink
    int stall;
    m_axis_tready_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = take_burst ? 0 : $urandom_range(0, GAP_MAX);
      if ($urandom_range(0, 31) == 0) take_burst = !take_burst;
      if (stall > 0) begin
        m_axis_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid_o);
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("piecewise_linear_arc_delay regression: fail");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    logic [CFG_DATA_W-1:0] draw [6];
    int p;
    int q;
    int j;
    rst_ni          <= 1'b0;
    s_axis_tdata_i  <= '0;
    s_axis_tvalid_i <= 1'b0;
    cfg_valid_i     <= 1'b0;
    cfg_index_i     <= '0;
    cfg_data_i      <= '0;
    aim_pc     = PIECE_COUNT_RST;
    aim_thr[0] = THRESHOLD_0_RST;
    aim_thr[1] = THRESHOLD_1_RST;
    aim_thr[2] = THRESHOLD_2_RST;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Register defaults straight after reset.
    send_query(16'd1, 16'd1, 32'h0000_0100, 17'd5);
    send_query(16'hFFFF, 16'hFFFF, 32'hFFFF_FFFF, 17'h1FFFF);
    wait_drained();

    // Three pieces with a falling third threshold.
    load_setting(2'd3, 16'h0000, 16'h0100, 16'h0080, 16'h0100, 16'hFFFF, 16'h0080);
    send_query(16'd0, 16'hFFFF, 32'hFFFF_FFFF, 17'h1FFFF);   // dummy arc
    send_query(16'd1, 16'd0, 32'h0000_0100, 17'd3);          // zero capacity
    send_query(16'd2, 16'd1, 32'h0000_0100, 17'd1);
    send_query(16'd3, 16'd10, 32'h0000_1000, 17'd0);         // no vehicles
    send_query(16'd4, 16'd10, 32'h0000_1000, 17'd10);        // exactly on a threshold
    send_query(16'd5, 16'd10, 32'h0000_1000, 17'd11);
    send_query(16'd6, 16'd10, 32'h0000_1000, 17'd6);         // between falling thresholds
    send_query(16'd7, 16'hFFFF, 32'hFFFF_FFFF, 17'h1FFFF);
    send_query(16'd8, 16'd1, 32'hFFFF_FFFF, 17'h1FFFF);      // clamped term, saturates
    send_query(16'd9, 16'd1, 32'h0000_0000, 17'h10000);
    send_query(16'h8000, 16'h8000, 32'h8000_0000, 17'h10000);
    send_query(16'hFFFF, 16'd1, 32'h0000_0100, 17'd2);
    wait_drained();

    // Every register at its maximum.
    load_setting(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_query(16'd1, 16'd1, 32'hFFFF_FFFF, 17'h1FFFF);
    send_query(16'd2, 16'hFFFF, 32'hFFFF_FFFF, 17'h1FFFF);
    send_query(16'd3, 16'd2, 32'hFFFF_FFFF, 17'd512);
    wait_drained();

    for (p = 0; p < RANDOM_PHASES; p++) begin
      for (j = 0; j < 6; j++) begin
        draw[j] = $urandom_range(0, 1) ? $urandom_range(0, 16'h0400) : $urandom;
      end
      case (p)
        0: load_setting(2'd3, 16'h0000, 16'h0100, 16'h0200, 16'h0100, 16'h0200, 16'h0400);
        1: load_setting(2'd0, draw[0], draw[1], draw[2], draw[3], draw[4], draw[5]);
        2: load_setting(2'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        3: load_setting(2'd2, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
        4: load_setting(2'd3, 16'h0200, 16'h0100, 16'h0000, draw[3], draw[4], draw[5]);
        5: load_setting(2'd1, 16'h0080, draw[1], draw[2], 16'hFFFF, draw[4], draw[5]);
        default: load_setting($urandom_range(0, 3), draw[0], draw[1], draw[2],
                              draw[3], draw[4], draw[5]);
      endcase
      for (q = 0; q < PHASE_QUERIES; q++) begin
        random_query();
        // Let the pipeline run completely dry once in the middle of a phase.
        if (p == 3 && q == PHASE_QUERIES / 2) wait_drained();
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    $display("Covered %0d queries under %0d register settings: zero to three pieces,",
             queries_sent, settings_loaded);
    $display("extreme and falling thresholds; %0d results checked, %0d saturated.",
             checked, saturated);
    if (fail_count == 0) begin
      $display("piecewise_linear_arc_delay regression: pass");
    end else begin
      $display("piecewise_linear_arc_delay regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pld_pkg.sv
sv/pld_div_stage.sv
sv/pld_cell.sv
sv/pld_out.sv
sv/piecewise_linear_arc_delay.sv
sim/pld_arc_delay_checker.sv
sim/piecewise_linear_arc_delay_tb.sv
